>>> hw/rtl/blm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package blm_pkg;
    localparam int MAX_SPEED_POINTS = 32;
    localparam int MAX_LOAD_POINTS = 32;
    localparam int MAX_CELLS = 1024;
    localparam int SAW = $clog2(MAX_SPEED_POINTS);
    localparam int LAW = $clog2(MAX_LOAD_POINTS);
    localparam int CAW = $clog2(MAX_CELLS);
    localparam int CNTW = 6;
    localparam int IDXW = 10;
    localparam int VALW = 16;

    localparam logic [1:0] FUNC_WR_SPEED = 2'd0;
    localparam logic [1:0] FUNC_WR_LOAD = 2'd1;
    localparam logic [1:0] FUNC_WR_CELL = 2'd2;
    localparam logic [1:0] FUNC_LOOKUP = 2'd3;

    localparam logic REG_SPEED_POINTS = 1'b0;
    localparam logic REG_LOAD_POINTS = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [IDXW-1:0] write_index;
        logic [VALW-1:0] write_value;
        logic [VALW-1:0] query_speed;
        logic [VALW-1:0] query_load;
    } blm_in_t;

    typedef struct packed {
        logic [VALW-1:0] value;
    } blm_out_t;

    typedef struct packed {
        logic index;
        logic [CNTW-1:0] data;
    } blm_cfg_t;
endpackage
`default_nettype wire

>>> hw/rtl/blm_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface blm_in_if;
    logic valid;
    logic ready;
    blm_pkg::blm_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface blm_out_if;
    logic valid;
    logic ready;
    blm_pkg::blm_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface blm_cfg_if;
    logic valid;
    logic ready;
    blm_pkg::blm_cfg_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/blm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module blm_div (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [33:0] num,
    input  wire logic signed [16:0] den,
    output logic busy,
    output logic signed [33:0] quo
);
    import blm_pkg::*;

    logic [5:0] cnt_reg;
    logic busy_reg;
    logic [33:0] q_reg;
    logic [33:0] r_reg;
    logic [16:0] d_reg;
    logic neg_reg;
    logic [33:0] r_sh;
    logic [34:0] diff;

    // restoring division on magnitudes, one quotient bit per cycle
    assign r_sh = {r_reg[32:0], q_reg[33]};
    assign diff = {1'b0, r_sh} - {18'd0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 6'd34;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num[33] ? 34'(-num) : num;
            d_reg <= den[16] ? 17'(-den) : den;
            r_reg <= '0;
            neg_reg <= num[33] ^ den[16];
        end
        else if (busy_reg)
        begin
            if (!diff[34])
            begin
                r_reg <= diff[33:0];
                q_reg <= {q_reg[32:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[32:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo = neg_reg ? 34'(-q_reg) : q_reg;
endmodule
`default_nettype wire

>>> hw/rtl/bilinear_map_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  payload
// in       in   func, write_index, write_value, query_speed, query_load
// result   out  value (lookups only)
// cfg      in   index, data (speed_points, load_points)
// a write item is taken while the block is idle, so writes can follow back to back
// a lookup walks the speed axis and then the load axis one point at a time, reads the
// four corners and runs three divisions; a result waits in the output register while
// the next item is taken; a second lookup holds at its end until the first has gone;
// reset clears control and sets both point counts to 16
module bilinear_map_lookup (
    input  wire logic clk,
    input  wire logic rst_n,
    blm_in_if.sink in,
    blm_out_if.source result,
    blm_cfg_if.sink cfg
);
    import blm_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SSRCH = 4'd1;
    localparam logic [3:0] ST_LSRCH = 4'd2;
    localparam logic [3:0] ST_C0 = 4'd3;
    localparam logic [3:0] ST_C1 = 4'd4;
    localparam logic [3:0] ST_C2 = 4'd5;
    localparam logic [3:0] ST_C3 = 4'd6;
    localparam logic [3:0] ST_CW = 4'd7;
    localparam logic [3:0] ST_MUL = 4'd8;
    localparam logic [3:0] ST_DIV = 4'd9;
    localparam logic [3:0] ST_WAIT = 4'd10;
    localparam logic [3:0] ST_OUT = 4'd11;

    logic [VALW-1:0] speed_mem [MAX_SPEED_POINTS];
    logic [VALW-1:0] load_mem [MAX_LOAD_POINTS];
    logic [VALW-1:0] cell_mem [MAX_CELLS];
    logic [VALW-1:0] speed_rd_reg, load_rd_reg, cell_rd_reg;

    logic [3:0] state_reg;
    logic [CNTW-1:0] speed_points_reg, load_points_reg;
    logic [SAW:0] ns_reg;
    logic [LAW:0] nl_reg;
    logic [SAW:0] i_reg;
    logic rd_pend_reg;
    logic [VALW-1:0] qs_reg, ql_reg;
    logic [SAW-1:0] sl_reg, sh_reg;
    logic [LAW-1:0] ll_reg, lh_reg;
    logic [VALW-1:0] slv_reg, shv_reg, llv_reg, lhv_reg;
    logic [VALW-1:0] c_reg [4];
    logic [1:0] step_reg;
    logic [VALW-1:0] a_reg, b_reg;
    logic signed [33:0] prod_reg;
    logic signed [16:0] span_reg;
    logic [VALW-1:0] out_reg;
    logic out_valid_reg;
    logic div_start;
    logic div_busy;
    logic signed [33:0] div_quo;

    logic [SAW:0] ns_c;
    logic [LAW:0] nl_c;
    logic [CAW-1:0] caddr;
    logic [CAW-1:0] row_base;
    logic [LAW-1:0] row_sel;
    logic [SAW-1:0] col_sel;
    logic [VALW-1:0] ax;
    logic [VALW-1:0] qq;
    logic [VALW-1:0] lo_v, hi_v, q_v, lv_v, hv_v;
    logic [VALW-1:0] step_res;
    logic accept_in;

    assign accept_in = in.valid && in.ready;
    assign in.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.payload.value = out_reg;

    always_comb
    begin
        if (speed_points_reg == '0)
            ns_c = (SAW+1)'(1);
        else if ({1'b0, speed_points_reg} > 7'(MAX_SPEED_POINTS))
            ns_c = (SAW+1)'(MAX_SPEED_POINTS);
        else
            ns_c = (SAW+1)'(speed_points_reg);
        if (load_points_reg == '0)
            nl_c = (LAW+1)'(1);
        else if ({1'b0, load_points_reg} > 7'(MAX_LOAD_POINTS))
            nl_c = (LAW+1)'(MAX_LOAD_POINTS);
        else
            nl_c = (LAW+1)'(load_points_reg);
    end

    // corner order: (ll,sl) (lh,sl) (ll,sh) (lh,sh)
    always_comb
    begin
        unique case (state_reg)
            ST_C0: begin row_sel = ll_reg; col_sel = sl_reg; end
            ST_C1: begin row_sel = lh_reg; col_sel = sl_reg; end
            ST_C2: begin row_sel = ll_reg; col_sel = sh_reg; end
            default: begin row_sel = lh_reg; col_sel = sh_reg; end
        endcase
        row_base = CAW'(32'(ns_reg) * 32'(row_sel));
        caddr = row_base + CAW'(col_sel);
    end

    // speed vs load search shares one walker
    assign ax = (state_reg == ST_SSRCH) ? speed_rd_reg : load_rd_reg;
    assign qq = (state_reg == ST_SSRCH) ? qs_reg : ql_reg;

    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                lo_v = c_reg[0]; hi_v = c_reg[1]; q_v = ql_reg; lv_v = llv_reg; hv_v = lhv_reg;
            end
            2'd1:
            begin
                lo_v = c_reg[2]; hi_v = c_reg[3]; q_v = ql_reg; lv_v = llv_reg; hv_v = lhv_reg;
            end
            default:
            begin
                lo_v = a_reg; hi_v = b_reg; q_v = qs_reg; lv_v = slv_reg; hv_v = shv_reg;
            end
        endcase
    end

    assign step_res = lo_v + ((span_reg == '0) ? '0 : div_quo[VALW-1:0]);
    assign div_start = (state_reg == ST_DIV);

    blm_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .num(prod_reg),
        .den(span_reg),
        .busy(div_busy),
        .quo(div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (accept_in && in.payload.func == FUNC_WR_SPEED
            && in.payload.write_index < IDXW'(MAX_SPEED_POINTS))
            speed_mem[in.payload.write_index[SAW-1:0]] <= in.payload.write_value;
        if (accept_in && in.payload.func == FUNC_WR_LOAD
            && in.payload.write_index < IDXW'(MAX_LOAD_POINTS))
            load_mem[in.payload.write_index[LAW-1:0]] <= in.payload.write_value;
        if (accept_in && in.payload.func == FUNC_WR_CELL
            && 32'(in.payload.write_index) < 32'(MAX_CELLS))
            cell_mem[in.payload.write_index[CAW-1:0]] <= in.payload.write_value;
        speed_rd_reg <= speed_mem[i_reg[SAW-1:0]];
        load_rd_reg <= load_mem[i_reg[LAW-1:0]];
        cell_rd_reg <= cell_mem[caddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            speed_points_reg <= CNTW'(16);
            load_points_reg <= CNTW'(16);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.payload.index == REG_SPEED_POINTS)
                    speed_points_reg <= cfg.payload.data;
                else
                    load_points_reg <= cfg.payload.data;
            end
            if (result.valid && result.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (accept_in && in.payload.func == FUNC_LOOKUP)
                        state_reg <= ST_SSRCH;
                ST_SSRCH:
                    if (rd_pend_reg && (i_reg + 1'b1 == ns_reg || ax >= qq))
                        state_reg <= ST_LSRCH;
                ST_LSRCH:
                    if (rd_pend_reg && (i_reg + 1'b1 == (SAW+1)'(nl_reg) || ax >= qq))
                        state_reg <= ST_C0;
                ST_C0: state_reg <= ST_C1;
                ST_C1: state_reg <= ST_C2;
                ST_C2: state_reg <= ST_C3;
                ST_C3: state_reg <= ST_CW;
                ST_CW: state_reg <= ST_MUL;
                ST_MUL: state_reg <= ST_DIV;
                ST_DIV: state_reg <= ST_WAIT;
                ST_WAIT:
                    if (!div_busy)
                    begin
                        if (step_reg == 2'd2)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                            state_reg <= ST_MUL;
                    end
                ST_OUT:
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                qs_reg <= in.payload.query_speed;
                ql_reg <= in.payload.query_load;
                ns_reg <= ns_c;
                nl_reg <= nl_c;
                i_reg <= '0;
                rd_pend_reg <= 1'b0;
                step_reg <= 2'd0;
            end
            ST_SSRCH, ST_LSRCH:
            begin
                // the read of point i_reg is registered and lands in the cycle after issue
                if (!rd_pend_reg)
                begin
                    rd_pend_reg <= 1'b1;
                end
                else
                begin
                    if (state_reg == ST_SSRCH)
                    begin
                        if (i_reg == '0)
                        begin
                            sl_reg <= '0; slv_reg <= ax;
                            sh_reg <= SAW'(ns_reg - 1'b1);
                        end
                        if (i_reg == ns_reg - 1'b1)
                            shv_reg <= ax;
                    end
                    else
                    begin
                        if (i_reg == '0)
                        begin
                            ll_reg <= '0; llv_reg <= ax;
                            lh_reg <= LAW'(nl_reg - 1'b1);
                        end
                        if (i_reg == (SAW+1)'(nl_reg) - 1'b1)
                            lhv_reg <= ax;
                    end
                    rd_pend_reg <= 1'b0;
                    if (ax < qq)
                    begin
                        if (state_reg == ST_SSRCH)
                        begin
                            sl_reg <= i_reg[SAW-1:0]; slv_reg <= ax;
                        end
                        else
                        begin
                            ll_reg <= i_reg[LAW-1:0]; llv_reg <= ax;
                        end
                    end
                    else if (ax > qq)
                    begin
                        if (state_reg == ST_SSRCH)
                        begin
                            sh_reg <= i_reg[SAW-1:0]; shv_reg <= ax;
                        end
                        else
                        begin
                            lh_reg <= i_reg[LAW-1:0]; lhv_reg <= ax;
                        end
                    end
                    else
                    begin
                        if (state_reg == ST_SSRCH)
                        begin
                            sl_reg <= i_reg[SAW-1:0]; slv_reg <= ax;
                            sh_reg <= i_reg[SAW-1:0]; shv_reg <= ax;
                        end
                        else
                        begin
                            ll_reg <= i_reg[LAW-1:0]; llv_reg <= ax;
                            lh_reg <= i_reg[LAW-1:0]; lhv_reg <= ax;
                        end
                    end
                    i_reg <= i_reg + 1'b1;
                    // last point reached or bracket found: restart index for the next axis
                    if (ax >= qq || i_reg + 1'b1 == ((state_reg == ST_SSRCH) ?
                        ns_reg : (SAW+1)'(nl_reg)))
                        i_reg <= '0;
                end
            end
            ST_C1: c_reg[0] <= cell_rd_reg;
            ST_C2: c_reg[1] <= cell_rd_reg;
            ST_C3: c_reg[2] <= cell_rd_reg;
            ST_CW: c_reg[3] <= cell_rd_reg;
            ST_MUL:
            begin
                prod_reg <= 34'(($signed({1'b0, hi_v}) - $signed({1'b0, lo_v}))
                    * ($signed({1'b0, q_v}) - $signed({1'b0, lv_v})));
                span_reg <= $signed({1'b0, hv_v}) - $signed({1'b0, lv_v});
            end
            ST_WAIT:
                if (!div_busy)
                begin
                    if (step_reg == 2'd0) a_reg <= step_res;
                    else if (step_reg == 2'd1) b_reg <= step_res;
                    step_reg <= step_reg + 2'd1;
                end
            // the last step result stays on step_res until the output register is free
            ST_OUT:
                if (!out_valid_reg || result.ready)
                    out_reg <= step_res;
            default: ;
        endcase
    end
endmodule
`default_nettype wire
